// ===== design/prefixed_radix_number_conversion_defines.svh =====
// ----------------------------------------------------------------------------
// Prefixed radix number conversion: assertion macros
// Shared property forms for the queue and the execution stage.
// ----------------------------------------------------------------------------
`ifndef PREFIXED_RADIX_NUMBER_CONVERSION_DEFINES_SVH
`define PREFIXED_RADIX_NUMBER_CONVERSION_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRNC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PRNC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/prnc_pkg.sv =====
// ----------------------------------------------------------------------------
// prnc_pkg
// Widths, character codes and the decoded word passed from front to back.
// ----------------------------------------------------------------------------
package prnc_pkg;

  localparam int MAX_TOKEN_LEN = 256;
  localparam int CH_W          = 8;
  localparam int VAL_W         = 64;
  localparam int RADIX_W       = 6;
  localparam int CNT_W         = 9;
  localparam int REM_W         = 10;
  localparam int QDEPTH        = 2;

  localparam logic [CH_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CH_W-1:0] CH_PCT    = 8'h25;
  localparam logic [CH_W-1:0] CH_QUOTE  = 8'h27;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CH_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_Z   = 8'h7A;

  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_BIN = 6'd2;
  localparam logic [RADIX_W-1:0] ALPHA_OFS = 6'd10;

  localparam logic [CNT_W-1:0] QUOTE_COUNT = 9'd3;

  typedef struct packed {
    logic [CH_W-1:0]        ch;
    logic                   first;
    logic                   last;
    logic [VAL_W-1:0]       start_value;
    logic                   is_prefix;
    logic [RADIX_W-1:0]     prefix_radix;
    logic                   is_quote;
    logic                   is_minus;
    logic                   digit_ok;
    logic [RADIX_W-1:0]     digit;
  } dec_word_t;

endpackage

// ===== design/prnc_in_if.sv =====
// ----------------------------------------------------------------------------
// prnc_in_if
// Character channel: one token character per word.
// ----------------------------------------------------------------------------
interface prnc_in_if import prnc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          ch;
  logic                     first;
  logic                     last;
  logic signed [VAL_W-1:0]  start_value;

  modport source (output valid, ch, first, last, start_value, input ready);
  modport sink   (input valid, ch, first, last, start_value, output ready);
endinterface

// ===== design/prnc_out_if.sv =====
// ----------------------------------------------------------------------------
// prnc_out_if
// Result channel: converted value with consumed and remaining counts.
// ----------------------------------------------------------------------------
interface prnc_out_if import prnc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  value;
  logic [CNT_W-1:0]         converted;
  logic signed [REM_W-1:0]  remaining;

  modport source (output valid, value, converted, remaining, input ready);
  modport sink   (input valid, value, converted, remaining, output ready);
endinterface

// ===== design/prnc_front.sv =====
// ----------------------------------------------------------------------------
// prnc_front
// Accepts characters and classifies them: prefix, quote, minus, digit value.
// ----------------------------------------------------------------------------
module prnc_front import prnc_pkg::*; (
  prnc_in_if.sink   in_chan,
  input  logic      q_full,
  output logic      push,
  output dec_word_t push_word
);

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;

  always_comb begin
    push_word             = '0;
    push_word.ch          = in_chan.ch;
    push_word.first       = in_chan.first;
    push_word.last        = in_chan.last;
    push_word.start_value = in_chan.start_value;
    push_word.is_prefix   = (in_chan.ch == CH_DOLLAR) || (in_chan.ch == CH_HASH) ||
                            (in_chan.ch == CH_PCT);
    push_word.prefix_radix = (in_chan.ch == CH_DOLLAR) ? RADIX_HEX :
                             (in_chan.ch == CH_HASH)   ? RADIX_DEC : RADIX_BIN;
    push_word.is_quote    = (in_chan.ch == CH_QUOTE);
    push_word.is_minus    = (in_chan.ch == CH_MINUS);
    if (in_chan.ch >= CH_ZERO && in_chan.ch <= CH_NINE) begin
      push_word.digit_ok = 1'b1;
      push_word.digit    = RADIX_W'(in_chan.ch - CH_ZERO);
    end else if (in_chan.ch >= CH_UP_A && in_chan.ch <= CH_UP_Z) begin
      push_word.digit_ok = 1'b1;
      push_word.digit    = RADIX_W'(in_chan.ch - CH_UP_A) + ALPHA_OFS;
    end else if (in_chan.ch >= CH_LO_A && in_chan.ch <= CH_LO_Z) begin
      push_word.digit_ok = 1'b1;
      push_word.digit    = RADIX_W'(in_chan.ch - CH_LO_A) + ALPHA_OFS;
    end
  end

endmodule

// ===== design/prnc_queue.sv =====
// ----------------------------------------------------------------------------
// prnc_queue
// Two-entry queue of decoded words between front and back.
// ----------------------------------------------------------------------------
`include "prefixed_radix_number_conversion_defines.svh"

module prnc_queue import prnc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dec_word_t push_word,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output dec_word_t head_word
);

  dec_word_t  mem_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'(QDEPTH));
  assign head_valid = (count_r != 2'd0);
  assign head_word  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  `PRNC_ASSERT_IMPL(a_q_count_bound, 1'b1, count_r <= 2'd2, "queue count over depth")
  `PRNC_ASSERT_NEXT(a_q_push_visible, push && !pop && count_r == 2'd0, head_valid, "pushed word not at head")

endmodule

// ===== design/prnc_back.sv =====
// ----------------------------------------------------------------------------
// prnc_back
// Runs the token state machine: sign, digit fold, quote literal, result.
// ----------------------------------------------------------------------------
`include "prefixed_radix_number_conversion_defines.svh"

module prnc_back import prnc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  dec_word_t          head_word,
  input  logic [RADIX_W-1:0] number_base,
  output logic               pop,
  prnc_out_if.source         out_chan
);

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_SIGN      = 6'b000010,
    PH_DIGITS    = 6'b000100,
    PH_HALT      = 6'b001000,
    PH_QUOTE2    = 6'b010000,
    PH_QUOTEREST = 6'b100000
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [VAL_W-1:0]    acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic [RADIX_W-1:0]  radix_r, radix_nxt;
  logic [CNT_W-1:0]    cons_r, cons_nxt;
  logic [CNT_W-1:0]    tot_r, tot_nxt;
  logic                stepping;
  logic                done;
  logic                emit;

  logic                out_valid_r;
  logic [VAL_W-1:0]    out_acc_r;
  logic                out_neg_r;
  logic [CNT_W-1:0]    out_cons_r;
  logic [REM_W-1:0]    out_rem_r;

  always_comb begin
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    radix_nxt = radix_r;
    cons_nxt  = cons_r;
    tot_nxt   = tot_r;
    phase_nxt = phase_r;
    stepping  = 1'b0;
    done      = 1'b0;

    if (head_word.first) begin
      acc_nxt   = head_word.start_value;
      neg_nxt   = 1'b0;
      cons_nxt  = '0;
      tot_nxt   = '0;
      phase_nxt = PH_SIGN;
      stepping  = 1'b1;
    end else if (phase_r != PH_IDLE) begin
      stepping = (tot_r < CNT_W'(MAX_TOKEN_LEN));
    end

    if (stepping) begin
      tot_nxt = tot_nxt + CNT_W'(1);
      if (head_word.first) begin
        if (head_word.is_prefix) begin
          radix_nxt = head_word.prefix_radix;
          cons_nxt  = CNT_W'(1);
          done      = 1'b1;
        end else if (head_word.is_quote) begin
          cons_nxt  = QUOTE_COUNT;
          acc_nxt   = '0;
          phase_nxt = PH_QUOTE2;
          done      = 1'b1;
        end else begin
          radix_nxt = number_base;
        end
      end
      // sign slot falls through to the digit check on the same character
      if (!done && phase_nxt == PH_SIGN) begin
        phase_nxt = PH_DIGITS;
        if (head_word.is_minus) begin
          neg_nxt  = 1'b1;
          cons_nxt = cons_nxt + CNT_W'(1);
          done     = 1'b1;
        end
      end
      if (!done) begin
        if (phase_nxt == PH_DIGITS) begin
          if (head_word.digit_ok && head_word.digit < radix_nxt) begin
            acc_nxt  = acc_nxt * {{(VAL_W-RADIX_W){1'b0}}, radix_nxt} +
                       {{(VAL_W-RADIX_W){1'b0}}, head_word.digit};
            cons_nxt = cons_nxt + CNT_W'(1);
          end else begin
            phase_nxt = PH_HALT;
          end
        end else if (phase_nxt == PH_QUOTE2) begin
          acc_nxt   = {{(VAL_W-CH_W){head_word.ch[CH_W-1]}}, head_word.ch};
          phase_nxt = PH_QUOTEREST;
        end
      end
    end

    emit = head_word.last && (head_word.first || phase_r != PH_IDLE);
    if (emit) begin
      phase_nxt = PH_IDLE;
    end
  end

  // hold the head while a finished result still waits downstream
  assign pop = head_valid && (!emit || !out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      radix_r     <= RADIX_DEC;
      cons_r      <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        radix_r <= radix_nxt;
        cons_r  <= cons_nxt;
        tot_r   <= tot_nxt;
      end
      if (pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_acc_r  <= acc_nxt;
      out_neg_r  <= neg_nxt;
      out_cons_r <= cons_nxt;
      out_rem_r  <= {1'b0, tot_nxt} - {1'b0, cons_nxt};
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.value     = out_neg_r ? -out_acc_r : out_acc_r;
  assign out_chan.converted = out_cons_r;
  assign out_chan.remaining = out_rem_r;

  `PRNC_ASSERT_IMPL(a_tot_bound, 1'b1, tot_r <= CNT_W'(MAX_TOKEN_LEN), "token count over limit")
  `PRNC_ASSERT_IMPL(a_cons_le_tot, phase_r == PH_SIGN || phase_r == PH_DIGITS || phase_r == PH_HALT, cons_r <= tot_r, "consumed exceeds received")
  `PRNC_ASSERT_NEXT(a_emit_shows, pop && emit, out_valid_r, "result word lost")

endmodule

// ===== design/prefixed_radix_number_conversion.sv =====
// A result word is loaded into the output register after its last character has passed through the queue.
// Throughput: one character per cycle while the queue has room; the 64x6 multiply-add in prnc_back sets the path.
// A two-word queue and the output register let input and output stall separately.
// Reset (synchronous, rst_n low): queue empty, token idle, number base 10.
// ----------------------------------------------------------------------------
// prefixed_radix_number_conversion
// Converts a token to a number one character per word, with radix prefixes.
// ----------------------------------------------------------------------------
module prefixed_radix_number_conversion import prnc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  prnc_in_if.sink            in_chan,
  prnc_out_if.source         out_chan,
  input  logic               cfg_we,
  input  logic [RADIX_W-1:0] cfg_wdata
);

  logic [RADIX_W-1:0] number_base_r;
  logic               q_full;
  logic               push;
  dec_word_t          push_word;
  logic               pop;
  logic               head_valid;
  dec_word_t          head_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= RADIX_DEC;
    end else if (cfg_we) begin
      number_base_r <= cfg_wdata;
    end
  end

  prnc_front u_front (
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  prnc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_word  (push_word),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  prnc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_word   (head_word),
    .number_base (number_base_r),
    .pop         (pop),
    .out_chan    (out_chan)
  );

endmodule

// ===== tb/prefixed_radix_number_conversion_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefixed_radix_number_conversion_tb
// Feeds token characters through the character channel and checks every result
// word against a cycle-free predictor of the conversion. The run steps through
// several number bases, including the odd ones, and several idle/stall mixes.
// ----------------------------------------------------------------------------
module prefixed_radix_number_conversion_tb;
  import prnc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    TOK_IDLE, TOK_SIGN, TOK_DIGITS, TOK_STOPPED, TOK_QUOTE_CHAR, TOK_QUOTE_TAIL
  } tok_state_t;

  typedef struct {
    logic [CH_W-1:0]  ch;
    logic             first;
    logic             last;
    logic [VAL_W-1:0] start_value;
    bit               drain_first;
  } char_word_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] converted;
    logic [REM_W-1:0] remaining;
  } number_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [RADIX_W-1:0] cfg_wdata;

  prnc_in_if  in_if ();
  prnc_out_if out_if ();

  prefixed_radix_number_conversion dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  char_word_t char_queue[$];
  number_t    expected_numbers[$];
  int         n_queued;
  int         n_accepted;
  int         n_useful;
  int         errors;
  int         cycles;
  int         send_idle_pct;
  int         recv_stall_pct;
  bit         tok_open;

  // predictor state
  logic [RADIX_W-1:0] base_reg;
  logic [VAL_W-1:0]   tok_acc;
  logic               tok_neg;
  logic [RADIX_W-1:0] tok_radix;
  int                 tok_used;
  int                 tok_seen;
  tok_state_t         tok_state;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Advance the predictor by one accepted character; returns 1 when a number results.
  function automatic bit convert_char(input char_word_t w, output number_t num);
    logic [CH_W-1:0] c;
    int unsigned     d;
    bit              take;
    c = w.ch;
    num = '{default: '0};
    if (w.first) begin
      tok_acc   = w.start_value;
      tok_neg   = 1'b0;
      tok_used  = 0;
      tok_seen  = 0;
      tok_state = TOK_SIGN;
    end else if (tok_state == TOK_IDLE) begin
      return 1'b0;
    end
    if (tok_seen < MAX_TOKEN_LEN) begin
      tok_seen++;
      take = 1'b1;
      if (w.first && (c == CH_DOLLAR || c == CH_HASH || c == CH_PCT)) begin
        tok_radix = (c == CH_DOLLAR) ? RADIX_HEX : ((c == CH_HASH) ? RADIX_DEC : RADIX_BIN);
        tok_used  = 1;
        take      = 1'b0;
      end else if (w.first && c == CH_QUOTE) begin
        tok_used  = QUOTE_COUNT;
        tok_acc   = '0;
        tok_state = TOK_QUOTE_CHAR;
        take      = 1'b0;
      end else begin
        if (w.first) tok_radix = base_reg;
        if (tok_state == TOK_SIGN) begin
          tok_state = TOK_DIGITS;
          if (c == CH_MINUS) begin
            tok_neg = 1'b1;
            tok_used++;
            take = 1'b0;
          end
        end
      end
      if (take && tok_state == TOK_DIGITS) begin
        if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
        else if (c >= CH_UP_A && c <= CH_UP_Z) d = c - CH_UP_A + ALPHA_OFS;
        else if (c >= CH_LO_A && c <= CH_LO_Z) d = c - CH_LO_A + ALPHA_OFS;
        else d = 255;
        if (d < tok_radix) begin
          tok_acc = tok_acc * tok_radix + d;
          tok_used++;
        end else begin
          tok_state = TOK_STOPPED;
        end
      end else if (take && tok_state == TOK_QUOTE_CHAR) begin
        tok_acc   = {{(VAL_W-CH_W){c[CH_W-1]}}, c};
        tok_state = TOK_QUOTE_TAIL;
      end
    end
    if (!w.last) return 1'b0;
    num.value     = tok_neg ? -tok_acc : tok_acc;
    num.converted = tok_used[CNT_W-1:0];
    num.remaining = REM_W'(tok_seen - tok_used);
    tok_state     = TOK_IDLE;
    return 1'b1;
  endfunction

  function automatic logic [VAL_W-1:0] rand_start();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return VAL_W'($signed($urandom_range(0, 2000)) - 1000);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Pick a character that is a valid digit in the given radix, or any decimal digit for radix 0.
  function automatic logic [CH_W-1:0] digit_char(input int radix);
    int lim;
    int d;
    lim = (radix > 36) ? 36 : radix;
    if (lim == 0) return CH_ZERO + CH_W'($urandom_range(0, 9));
    d = $urandom_range(0, lim - 1);
    if (d < 10) return CH_ZERO + CH_W'(d);
    if ($urandom_range(0, 1)) return CH_UP_A + CH_W'(d - 10);
    return CH_LO_A + CH_W'(d - 10);
  endfunction

  task automatic push_char(input logic [CH_W-1:0] c, input logic first, input logic last,
                           input logic [VAL_W-1:0] sv, input bit drain_first);
    char_word_t w;
    w.ch          = c;
    w.first       = first;
    w.last        = last;
    w.start_value = sv;
    w.drain_first = drain_first;
    char_queue.push_back(w);
    n_queued++;
  endtask

  // Queue one random token (or a burst of stray characters while no token is open).
  task automatic add_token(input bit force_long);
    logic [CH_W-1:0] tok[$];
    int  style;
    int  radix;
    int  n;
    bit  keep_open;
    bit  drain;
    style     = $urandom_range(0, 199);
    drain     = ($urandom_range(0, 39) == 0);
    keep_open = 1'b0;
    radix     = base_reg;
    if (!force_long && style < 8 && !tok_open) begin
      n = $urandom_range(1, 3);
      repeat (n) push_char(CH_W'($urandom), 1'b0, 1'($urandom_range(0, 1)), rand_start(), 0);
      return;
    end
    if (force_long || style == 8) begin
      n = $urandom_range(MAX_TOKEN_LEN - 1, MAX_TOKEN_LEN + 6);
      repeat (n) tok.push_back(digit_char(radix));
    end else if (style < 30) begin
      tok.push_back(CH_QUOTE);
      if ($urandom_range(0, 99) < 85) tok.push_back(CH_W'($urandom));
      n = $urandom_range(0, 2);
      repeat (n) tok.push_back(CH_W'($urandom));
    end else if (style < 50) begin
      n = $urandom_range(1, 6);
      repeat (n) tok.push_back(CH_W'($urandom));
    end else begin
      case ($urandom_range(0, 6))
        0: begin tok.push_back(CH_DOLLAR); radix = RADIX_HEX; end
        1: begin tok.push_back(CH_HASH);   radix = RADIX_DEC; end
        2: begin tok.push_back(CH_PCT);    radix = RADIX_BIN; end
        default: ;
      endcase
      if ($urandom_range(0, 99) < 40) tok.push_back(CH_MINUS);
      n = $urandom_range(0, 16);
      repeat (n) tok.push_back(digit_char(radix));
      if ($urandom_range(0, 99) < 25) begin
        tok.push_back(CH_W'($urandom));
        n = $urandom_range(0, 3);
        repeat (n) tok.push_back(digit_char(radix));
      end
      if (tok.size() == 0) tok.push_back(digit_char(radix));
      keep_open = ($urandom_range(0, 99) < 8);
    end
    foreach (tok[i]) begin
      push_char(tok[i], i == 0, !keep_open && i == tok.size() - 1, rand_start(),
                drain && i == 0);
    end
    n_useful += tok.size();
    tok_open = keep_open;
  endtask

  task automatic cfg_write(input logic [RADIX_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    base_reg  = v;
  endtask

  // Hold until every queued word is taken and every number has come back.
  task automatic wait_quiet();
    while (char_queue.size() != 0 || n_accepted != n_queued || expected_numbers.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // character driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid       <= 1'b0;
      in_if.ch          <= '0;
      in_if.first       <= 1'b0;
      in_if.last        <= 1'b0;
      in_if.start_value <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      // a word taken at this edge may still owe a number, so hold a drain word until none is owed
      if (char_queue.size() != 0 &&
          !(char_queue[0].drain_first && (expected_numbers.size() != 0 || in_if.valid)) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.valid       <= 1'b1;
        in_if.ch          <= char_queue[0].ch;
        in_if.first       <= char_queue[0].first;
        in_if.last        <= char_queue[0].last;
        in_if.start_value <= char_queue[0].start_value;
        void'(char_queue.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: check result words first, then predict from the accepted character
  always @(posedge clk) begin : monitor
    number_t    want;
    number_t    got;
    char_word_t w;
    if (rst_n) begin
      cycles++;
      if (out_if.valid && out_if.ready) begin
        if (expected_numbers.size() == 0) begin
          $error("unexpected result word: value %0d", $signed(out_if.value));
          errors++;
        end else begin
          want = expected_numbers.pop_front();
          got.value     = out_if.value;
          got.converted = out_if.converted;
          got.remaining = out_if.remaining;
          if (got.value !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value), $signed(got.value));
            errors++;
          end
          if (got.converted !== want.converted) begin
            $error("converted: expected %0d, got %0d", want.converted, got.converted);
            errors++;
          end
          if (got.remaining !== want.remaining) begin
            $error("remaining: expected %0d, got %0d", $signed(want.remaining),
                   $signed(got.remaining));
            errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        n_accepted++;
        w.ch          = in_if.ch;
        w.first       = in_if.first;
        w.last        = in_if.last;
        w.start_value = in_if.start_value;
        w.drain_first = 1'b0;
        if (convert_char(w, want)) expected_numbers.push_back(want);
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int bases[7]   = '{16, 2, 36, 0, 1, 63, 10};
    int send_pct[7] = '{0, 83, 0, 20, 20, 0, 20};
    int recv_pct[7] = '{0, 0, 83, 20, 20, 0, 20};
    int counts[7]  = '{400, 300, 300, 150, 150, 150, 200};
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    n_queued          = 0;
    n_accepted        = 0;
    n_useful          = 0;
    errors            = 0;
    cycles            = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    tok_open          = 1'b0;
    base_reg          = RADIX_DEC;
    tok_acc           = '0;
    tok_neg           = 1'b0;
    tok_radix         = RADIX_DEC;
    tok_used          = 0;
    tok_seen          = 0;
    tok_state         = TOK_IDLE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    cfg_write(RADIX_DEC);
    // stray character with no token open: dropped
    push_char(CH_ZERO + 8'd5, 1'b0, 1'b1, '0, 0);
    push_char(CH_NINE - 8'd2, 1'b1, 1'b1, '0, 0);
    // hex prefix, mixed-case letters, largest start value
    push_char(CH_DOLLAR, 1'b1, 1'b0, {1'b0, {(VAL_W-1){1'b1}}}, 0);
    push_char(CH_LO_Z - 8'd20, 1'b0, 1'b0, '0, 0);
    push_char(CH_UP_Z - 8'd20, 1'b0, 1'b1, '0, 0);
    // lone minus negates the smallest start value
    push_char(CH_MINUS, 1'b1, 1'b1, {1'b1, {(VAL_W-1){1'b0}}}, 0);
    // quote with its character missing, then one with a high byte
    push_char(CH_QUOTE, 1'b1, 1'b1, '1, 0);
    push_char(CH_QUOTE, 1'b1, 1'b0, '0, 0);
    push_char(8'hFF, 1'b0, 1'b1, '0, 0);
    // binary prefix, minus, digits, stop at '2', later digit ignored
    push_char(CH_PCT, 1'b1, 1'b0, '0, 0);
    push_char(CH_MINUS, 1'b0, 1'b0, '0, 0);
    push_char(CH_ZERO + 8'd1, 1'b0, 1'b0, '0, 0);
    push_char(CH_ZERO, 1'b0, 1'b0, '0, 0);
    push_char(CH_ZERO + 8'd2, 1'b0, 1'b0, '0, 0);
    push_char(CH_ZERO + 8'd1, 1'b0, 1'b1, '0, 0);
    // prefix with nothing after it
    push_char(CH_HASH, 1'b1, 1'b1, 64'd77, 0);
    // abandoned token restarted by a new first character
    push_char(CH_ZERO + 8'd1, 1'b1, 1'b0, 64'd3, 0);
    push_char(CH_ZERO + 8'd2, 1'b0, 1'b0, '0, 0);
    push_char(CH_HASH, 1'b1, 1'b0, '0, 0);
    push_char(CH_NINE, 1'b0, 1'b1, '0, 0);
    // high byte is never a digit
    push_char(8'h80, 1'b1, 1'b1, 64'd5, 0);
    wait_quiet();

    for (int i = 0; i < 7; i++) begin
      if (i == 6) bases[i] = $urandom_range(3, 35);
      cfg_write(RADIX_W'(bases[i]));
      send_idle_pct  = send_pct[i];
      recv_stall_pct = recv_pct[i];
      n_useful       = 0;
      if (i == 0) add_token(1'b1);
      while (n_useful < counts[i]) add_token(1'b0);
      wait_quiet();
    end

    if (errors == 0 && expected_numbers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/prnc_pkg.sv
design/prnc_in_if.sv
design/prnc_out_if.sv
design/prnc_front.sv
design/prnc_queue.sv
design/prnc_back.sv
design/prefixed_radix_number_conversion.sv
tb/prefixed_radix_number_conversion_tb.sv
